FILE: hdl/ffa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit free-list allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  localparam int ADDR_W = 32;
  localparam int REQ_W  = 24;
  localparam int SIZE_W = 25;
  localparam int CFG_W  = 32;

  localparam int DEF_LIST_ENTRIES = 16;
  localparam int DEF_GROW_CHUNK   = 65536;
  localparam int DEF_MIN_BLOCK    = 16;
  localparam int DEF_WORD_BYTES   = 4;

  localparam logic [ADDR_W-1:0] RST_POOL_BASE   = 32'd0;
  localparam logic [REQ_W-1:0]  RST_POOL_SIZE   = 24'd100;
  localparam logic [ADDR_W-1:0] RST_BREAK_BASE  = 32'd65536;
  localparam logic [ADDR_W-1:0] RST_BREAK_LIMIT = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CFG_POOL_BASE   = 2'd0,
    CFG_POOL_SIZE   = 2'd1,
    CFG_BREAK_BASE  = 2'd2,
    CFG_BREAK_LIMIT = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOMEM = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [REQ_W-1:0]  request_size;
    logic [ADDR_W-1:0] user_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] alloc_address;
    status_t           status;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } entry_t;

endpackage

`default_nettype wire

FILE: hdl/ffa_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffa_mem
// Free-list store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ffa_mem
  import ffa_pkg::*;
#(
  parameter int DEPTH = DEF_LIST_ENTRIES,
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [IW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic [IW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/ffa_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffa_core
// Sequencer: first-fit scan, split, removal shift, head insertion, growth.
// ---------------------------------------------------------------------------
`default_nettype none

module ffa_core
  import ffa_pkg::*;
#(
  parameter int LIST_ENTRIES = DEF_LIST_ENTRIES,
  parameter int GROW_CHUNK   = DEF_GROW_CHUNK,
  parameter int MIN_BLOCK    = DEF_MIN_BLOCK,
  parameter int WORD_BYTES   = DEF_WORD_BYTES,
  localparam int IW = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1,
  localparam int CW = $clog2(LIST_ENTRIES + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire cfg_index_t       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire in_item_t         req,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output out_item_t             rsp,
  output logic                  mem_we,
  output logic [IW-1:0]         mem_waddr,
  output entry_t                mem_wdata,
  output logic [IW-1:0]         mem_raddr,
  input  wire entry_t           mem_rdata
);

  localparam int GW = SIZE_W + 1;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_GROW, S_REMOVE, S_SHIFT, S_RESP
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] pool_base, break_base, break_limit, heap_break;
  logic [REQ_W-1:0]  pool_size;
  logic [CW-1:0]     cnt, rd, chk, wptr;
  logic              pend;
  logic [SIZE_W-1:0] nsz;
  logic [ADDR_W-1:0] uaddr, res_addr;
  status_t           res_st;

  logic [SIZE_W-1:0] n0, n1, n_in, rem;
  logic [GW-1:0]     grow, grow_rem;
  logic [ADDR_W:0]   nb;
  logic              fit, exact, last, full;
  entry_t            init_ent;

  always_comb begin
    n0   = SIZE_W'(req.request_size) + SIZE_W'(WORD_BYTES);
    n1   = (n0 < SIZE_W'(MIN_BLOCK)) ? SIZE_W'(MIN_BLOCK) : n0;
    n_in = (n1 + SIZE_W'(WORD_BYTES - 1)) & ~SIZE_W'(WORD_BYTES - 1);
    grow = (GW'(nsz) + GW'(GROW_CHUNK - 1)) & ~GW'(GROW_CHUNK - 1);
    grow_rem = grow - GW'(nsz);
    nb    = {1'b0, heap_break} + (ADDR_W + 1)'(grow);
    fit   = mem_rdata.size >= nsz;
    exact = mem_rdata.size == nsz;
    rem   = mem_rdata.size - nsz;
    last  = chk == (cnt - CW'(1));
    full  = cnt >= CW'(LIST_ENTRIES);
  end

  always_comb begin
    init_ent.addr = pool_base;
    init_ent.size = SIZE_W'(pool_size);
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_POOL_BASE:   init_ent.addr = cfg_data;
        CFG_POOL_SIZE:   init_ent.size = SIZE_W'(cfg_data[REQ_W-1:0]);
        CFG_BREAK_BASE,
        CFG_BREAK_LIMIT: ;
        default:         ;
      endcase
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = init_ent;
    mem_raddr = rd[IW-1:0];
    unique case (state)
      S_INIT: mem_we = 1'b1;
      S_IDLE: mem_we = cfg_we;
      S_SCAN: begin
        if (pend && fit && !exact) begin
          mem_we         = 1'b1;
          mem_waddr      = chk[IW-1:0];
          mem_wdata.addr = mem_rdata.addr;
          mem_wdata.size = rem;
        end
      end
      S_GROW: begin
        if (!full && nb <= {1'b0, break_limit} && grow_rem != '0) begin
          mem_we         = 1'b1;
          mem_waddr      = cnt[IW-1:0];
          mem_wdata.addr = heap_break;
          mem_wdata.size = SIZE_W'(grow_rem);
        end
      end
      S_REMOVE: begin
        mem_we    = pend;
        mem_waddr = wptr[IW-1:0];
        mem_wdata = mem_rdata;
      end
      S_SHIFT: begin
        mem_raddr = IW'(rd - CW'(1));
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = wptr[IW-1:0];
          mem_wdata = mem_rdata;
        end else if (rd == '0) begin
          mem_we         = 1'b1;
          mem_waddr      = '0;
          mem_wdata.addr = uaddr - ADDR_W'(WORD_BYTES);
          mem_wdata.size = nsz;
        end
      end
      S_RESP: ;
      default: ;
    endcase
  end

  assign req_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      pool_base   <= RST_POOL_BASE;
      pool_size   <= RST_POOL_SIZE;
      break_base  <= RST_BREAK_BASE;
      break_limit <= RST_BREAK_LIMIT;
      heap_break  <= RST_BREAK_BASE;
      cnt         <= CW'(1);
      rd          <= '0;
      chk         <= '0;
      wptr        <= '0;
      pend        <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_RESP) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        cnt <= CW'(1);
        unique case (cfg_index)
          CFG_POOL_BASE:   pool_base   <= cfg_data;
          CFG_POOL_SIZE:   pool_size   <= cfg_data[REQ_W-1:0];
          CFG_BREAK_BASE:  break_base  <= cfg_data;
          CFG_BREAK_LIMIT: break_limit <= cfg_data;
          default: ;
        endcase
        heap_break <= (cfg_index == CFG_BREAK_BASE) ? cfg_data : break_base;
      end
      unique case (state)
        S_INIT: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            nsz      <= n_in;
            uaddr    <= req.user_address;
            pend     <= 1'b0;
            res_addr <= '0;
            if (req.op == OP_ALLOC) begin
              rd     <= '0;
              res_st <= ST_OK;
              state  <= (cnt == '0) ? S_GROW : S_SCAN;
            end else if (full) begin
              res_st <= ST_FULL;
              state  <= S_RESP;
            end else begin
              rd     <= cnt;
              res_st <= ST_OK;
              state  <= S_SHIFT;
            end
          end
        end
        S_SCAN: begin
          if (pend && fit) begin
            if (exact) begin
              res_addr <= mem_rdata.addr + ADDR_W'(WORD_BYTES);
              rd       <= chk + CW'(1);
              pend     <= 1'b0;
              state    <= S_REMOVE;
            end else begin
              res_addr <= mem_rdata.addr + ADDR_W'(rem) + ADDR_W'(WORD_BYTES);
              state    <= S_RESP;
            end
          end else if (pend && last) begin
            state <= S_GROW;
          end else begin
            pend <= 1'b1;
            chk  <= rd;
            rd   <= rd + CW'(1);
          end
        end
        S_GROW: begin
          if (full) begin
            res_st <= ST_FULL;
          end else if (nb > {1'b0, break_limit}) begin
            res_st <= ST_NOMEM;
          end else begin
            heap_break <= nb[ADDR_W-1:0];
            res_addr   <= heap_break + ADDR_W'(grow_rem) + ADDR_W'(WORD_BYTES);
            if (grow_rem != '0) begin
              cnt <= cnt + CW'(1);
            end
          end
          state <= S_RESP;
        end
        S_REMOVE: begin
          if (rd < cnt) begin
            pend <= 1'b1;
            wptr <= rd - CW'(1);
            rd   <= rd + CW'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              cnt   <= cnt - CW'(1);
              state <= S_RESP;
            end
          end
        end
        S_SHIFT: begin
          if (rd != '0) begin
            pend <= 1'b1;
            wptr <= rd;
            rd   <= rd - CW'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              cnt   <= cnt + CW'(1);
              state <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid         <= 1'b1;
            rsp.alloc_address <= res_addr;
            rsp.status        <= res_st;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/first_fit_free_list_allocator.sv
`timescale 1ns / 1ps
// Allocate: a first-fit scan reads one list entry per cycle; an exact fit then
//   shifts the tail of the list down. Free shifts the entries up and inserts
//   the freed block at the head; a full list refuses it.
// One item at a time: no new item is taken until the last result is in rsp.
// Reset: synchronous; after reset an init state writes the initial pool entry,
//   during which no item is taken. A write while idle reinitialises the list.
// ---------------------------------------------------------------------------
// first_fit_free_list_allocator
// Allocate and free over an ordered free list held in a synchronous memory.
// ---------------------------------------------------------------------------
`default_nettype none

module first_fit_free_list_allocator
  import ffa_pkg::*;
#(
  parameter int LIST_ENTRIES = DEF_LIST_ENTRIES,
  parameter int GROW_CHUNK   = DEF_GROW_CHUNK,
  parameter int MIN_BLOCK    = DEF_MIN_BLOCK,
  parameter int WORD_BYTES   = DEF_WORD_BYTES
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire cfg_index_t       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire in_item_t         req,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output out_item_t             rsp
);

  localparam int IW = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1;

  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  ffa_core #(
    .LIST_ENTRIES(LIST_ENTRIES),
    .GROW_CHUNK  (GROW_CHUNK),
    .MIN_BLOCK   (MIN_BLOCK),
    .WORD_BYTES  (WORD_BYTES)
  ) u_core (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .req_valid, .req_ready, .req,
    .rsp_valid, .rsp_ready, .rsp,
    .mem_we, .mem_waddr, .mem_wdata, .mem_raddr, .mem_rdata
  );

  ffa_mem #(
    .DEPTH(LIST_ENTRIES)
  ) u_mem (
    .clk,
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("item taken while busy");

  a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.alloc_address == '0)
    else $error("address given on failed item");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_NOMEM
                   || rsp.status == ST_FULL))
    else $error("bad status code");

  a_init_after_reset: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("item taken before pool entry written");
`endif

endmodule

`default_nettype wire

FILE: sim/first_fit_free_list_allocator_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// first_fit_free_list_allocator_test
// Drives allocate and free items through the allocator under random idling
// and stalls, predicts each status and address from a model of the free list
// and heap break, and compares every result item field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module first_fit_free_list_allocator_test;
  import ffa_pkg::*;

  localparam int NLIST    = 16;
  localparam int CHUNK    = 65536;
  localparam int MINBLK   = 16;
  localparam int WBYTES   = 4;
  localparam int WATCHDOG = 20000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  cfg_index_t       cfg_index = CFG_POOL_BASE;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             req_valid = 1'b0;
  logic             req_ready;
  in_item_t         req = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  out_item_t        rsp;

  first_fit_free_list_allocator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req_valid(req_valid), .req_ready(req_ready),
    .req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // free-list shadow
  logic [31:0] fl_addr [NLIST];
  logic [31:0] fl_size [NLIST];
  int          fl_count;
  logic [31:0] heap_top;
  logic [31:0] r_pool_base, r_pool_size, r_break_base, r_break_limit;

  in_item_t    pending_items [$];
  out_item_t   expected_rsps [$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;
  wire         recv_hold = hold_cycles > 0;
  bit          failed = 0;
  int          quiet_cycles = 0;
  // recent allocations, used to build plausible frees
  logic [31:0] live_addr [$];
  logic [23:0] live_size [$];

  function automatic logic [31:0] block_bytes(logic [23:0] r);
    logic [31:0] n;
    n = {8'd0, r} + WBYTES;
    if (n < MINBLK) n = MINBLK;
    if (n % WBYTES != 0) n = (n / WBYTES + 1) * WBYTES;
    return n;
  endfunction

  function automatic void list_reinit();
    fl_addr[0] = r_pool_base;
    fl_size[0] = r_pool_size;
    fl_count   = 1;
    heap_top   = r_break_base;
  endfunction

  function automatic logic [31:0] carve(int i, logic [31:0] n);
    logic [31:0] a;
    a = fl_addr[i];
    if (fl_size[i] == n) begin
      for (int k = i; k + 1 < fl_count; k++) begin
        fl_addr[k] = fl_addr[k+1];
        fl_size[k] = fl_size[k+1];
      end
      fl_count--;
      return a;
    end
    fl_size[i] -= n;
    return a + fl_size[i];
  endfunction

  function automatic out_item_t allocator_predict(in_item_t it);
    out_item_t   o;
    logic [31:0] n;
    logic [63:0] grow, nb;
    o.alloc_address = '0;
    o.status = ST_OK;
    n = block_bytes(it.request_size);
    if (it.op == OP_ALLOC) begin
      for (int i = 0; i < fl_count; i++) begin
        if (fl_size[i] >= n) begin
          o.alloc_address = carve(i, n) + WBYTES;
          return o;
        end
      end
      if (fl_count >= NLIST) begin
        o.status = ST_FULL;
        return o;
      end
      grow = 64'(n);
      if (grow % CHUNK != 0) grow = (grow / CHUNK + 1) * CHUNK;
      nb = {32'd0, heap_top} + grow;
      if (nb > {32'd0, r_break_limit}) begin
        o.status = ST_NOMEM;
        return o;
      end
      fl_addr[fl_count] = heap_top;
      fl_size[fl_count] = grow[31:0];
      fl_count++;
      heap_top = nb[31:0];
      o.alloc_address = carve(fl_count - 1, n) + WBYTES;
    end else begin
      if (fl_count >= NLIST) begin
        o.status = ST_FULL;
        return o;
      end
      for (int k = fl_count; k > 0; k--) begin
        fl_addr[k] = fl_addr[k-1];
        fl_size[k] = fl_size[k-1];
      end
      fl_addr[0] = it.user_address - WBYTES;
      fl_size[0] = n;
      fl_count++;
    end
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req       <= pending_items.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // predict on acceptance
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) begin
      out_item_t e;
      e = allocator_predict(req);
      expected_rsps.push_back(e);
      if (req.op == OP_ALLOC && e.status == ST_OK && live_addr.size() < 64) begin
        live_addr.push_back(e.alloc_address);
        live_size.push_back(req.request_size);
      end
    end
  end

  // long receiver hold
  always @(posedge clk) begin
    if (hold_cycles > 0)
      hold_cycles <= hold_cycles - 1;
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected item addr=%h status=%0d", $time,
                   rsp.alloc_address, rsp.status);
          failed = 1;
        end else begin
          out_item_t e;
          e = expected_rsps.pop_front();
          if (rsp.alloc_address !== e.alloc_address) begin
            $display("%0t: alloc_address expected %h actual %h", $time,
                     e.alloc_address, rsp.alloc_address);
            failed = 1;
          end
          if (rsp.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     e.status, rsp.status);
            failed = 1;
          end
        end
      end
      rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || rst || cfg_we
        || recv_hold)
      quiet_cycles <= 0;
    else if (pending_items.size() > 0 || expected_rsps.size() > 0 || req_valid)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(cfg_index_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_POOL_BASE:   r_pool_base = v;
      CFG_POOL_SIZE:   r_pool_size = {8'd0, v[23:0]};
      CFG_BREAK_BASE:  r_break_base = v;
      default:         r_break_limit = v;
    endcase
    list_reinit();
    live_addr.delete();
    live_size.delete();
    repeat (3) @(posedge clk);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_rsps.size() > 0 || req_valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic push_item(op_t op, logic [23:0] sz, logic [31:0] ua);
    in_item_t it;
    it.op = op;
    it.request_size = sz;
    it.user_address = ua;
    pending_items.push_back(it);
  endtask

  task automatic push_random();
    int          pick;
    logic [23:0] sz;
    pick = $urandom_range(99);
    case ($urandom_range(9))
      0:       sz = 24'($urandom);
      1:       sz = 24'($urandom_range(70000, 16777215));
      2, 3:    sz = 24'($urandom_range(1, 12));
      default: sz = 24'($urandom_range(1, 300));
    endcase
    if (pick < 55) begin
      push_item(OP_ALLOC, sz, $urandom);
    end else if (pick < 90 && live_addr.size() > 0) begin
      int j;
      j = $urandom_range(live_addr.size() - 1);
      push_item(OP_FREE, live_size[j], live_addr[j]);
      live_addr.delete(j);
      live_size.delete(j);
    end else begin
      push_item(OP_FREE, sz, $urandom);
    end
  endtask

  task automatic random_phase(int count, int idle, int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      push_random();
      // keep the predicted live set fresh by letting items flow
      if (pending_items.size() > 8)
        while (pending_items.size() > 2) @(posedge clk);
    end
    drain();
  endtask

  initial begin
    r_pool_base   = RST_POOL_BASE;
    r_pool_size   = {8'd0, RST_POOL_SIZE};
    r_break_base  = RST_BREAK_BASE;
    r_break_limit = RST_BREAK_LIMIT;
    list_reinit();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    // directed: reset state
    push_item(OP_ALLOC, 24'd0, 32'd0);
    push_item(OP_ALLOC, 24'd1, 32'hFFFF_FFFF);
    push_item(OP_ALLOC, 24'd60, 32'd0);
    push_item(OP_ALLOC, 24'd200, 32'd0);
    push_item(OP_ALLOC, 24'hFF_FFFF, 32'd0);
    push_item(OP_FREE, 24'd1, 32'd0);
    push_item(OP_FREE, 24'hFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 14; i++) push_item(OP_FREE, 24'd5, 32'h1000 + i * 32);
    push_item(OP_ALLOC, 24'hFF_FFFF, 32'd0);
    drain();

    // tight limit: out of memory, wrapped addresses
    write_reg(CFG_POOL_BASE, 32'hFFFF_FFF0);
    write_reg(CFG_POOL_SIZE, 32'h00FF_FFFF);
    write_reg(CFG_BREAK_BASE, 32'hFFFE_0000);
    write_reg(CFG_BREAK_LIMIT, 32'hFFFF_0000);
    push_item(OP_ALLOC, 24'hFF_FFFF, 32'd0);
    push_item(OP_ALLOC, 24'hFF_FFF0, 32'd0);
    push_item(OP_FREE, 24'd3, 32'd0);
    drain();

    random_phase(300, 0, 0);
    write_reg(CFG_POOL_SIZE, 32'd0);
    write_reg(CFG_BREAK_LIMIT, 32'h0020_0000);
    write_reg(CFG_BREAK_BASE, 32'd0);
    random_phase(300, 77, 0);
    write_reg(CFG_POOL_BASE, 32'h8000_0000);
    write_reg(CFG_POOL_SIZE, 32'd4096);
    write_reg(CFG_BREAK_LIMIT, 32'hFFFF_FFFF);
    random_phase(300, 0, 77);

    // long receiver hold while items keep coming
    hold_cycles = 600;
    for (int i = 0; i < 30; i++) push_random();
    wait (hold_cycles == 0);
    drain();

    write_reg(CFG_BREAK_BASE, 32'hFFF0_0000);
    random_phase(300, 13, 13);
    write_reg(CFG_POOL_BASE, 32'd0);
    write_reg(CFG_POOL_SIZE, 32'd100);
    write_reg(CFG_BREAK_BASE, 32'd65536);
    random_phase(300, 0, 0);

    if (failed) begin
      $display("TEST FAILED");
    end else begin
      $display("TEST PASSED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
hdl/ffa_pkg.sv
hdl/ffa_mem.sv
hdl/ffa_core.sv
hdl/first_fit_free_list_allocator.sv
sim/first_fit_free_list_allocator_test.sv
